@@ sv/axpl_pkg.sv @@
package axpl_pkg;

	// Table geometry
	localparam int MAX_POINTS = 8;
	localparam int NUM_AXES   = 4;
	localparam int NUM_CFG    = 4;
	localparam int PT_W       = $clog2(MAX_POINTS);
	localparam int DEPTH      = NUM_AXES * MAX_POINTS;
	localparam int ADDR_W     = $clog2(DEPTH);

	// Field widths
	localparam int CNT_W   = 4;
	localparam int AXIS_W  = 2;
	localparam int SLOT_W  = 3;
	localparam int BL_W    = 17;
	localparam int DS_W    = 32;
	localparam int SEG_W   = 3;
	localparam int PADDR_W = $clog2(NUM_CFG) + 2;
	localparam int PDATA_W = 32;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Interpolation datapath
	localparam int MAG_W     = DS_W + 1;
	localparam int PROD_W    = BL_W + MAG_W;
	localparam int REM_W     = BL_W;
	localparam int DIV_STEPS = MAG_W;
	localparam int DIVC_W    = $clog2(DIV_STEPS + 1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef enum logic [1:0] {
		REGION_BELOW  = 2'd0,
		REGION_INTERP = 2'd1,
		REGION_ABOVE  = 2'd2
	} region_t;

	typedef struct packed {
		logic                   op;
		logic [AXIS_W-1:0]      axis_index;
		logic [SLOT_W-1:0]      point_index;
		logic [BL_W-1:0]        blend_coord;
		logic signed [DS_W-1:0] design_coord;
		logic [BL_W-1:0]        query_coord;
	} req_t;

	typedef struct packed {
		logic signed [DS_W-1:0] mapped_design;
		region_t                region;
		logic [SEG_W-1:0]       segment;
	} rsp_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [AXIS_W-1:0]      axis;
		logic [PT_W-1:0]        point;
		logic [PT_W-1:0]        last;
		logic [BL_W-1:0]        blend;
		logic signed [DS_W-1:0] design_val;
		logic [BL_W-1:0]        query;
	} cmd_t;

	typedef struct packed {
		logic [BL_W-1:0]        blend;
		logic signed [DS_W-1:0] design_val;
	} mem_word_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FIRST,
		BK_SCAN,
		BK_MUL,
		BK_DIV,
		BK_FIX,
		BK_OUT
	} bk_state_t;

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [AXIS_W-1:0] axis,
		input logic [PT_W-1:0] pt);
		return ADDR_W'(int'(axis) * MAX_POINTS + int'(pt));
	endfunction

endpackage

@@ sv/axis_piecewise_linear_unmap.sv @@
// Channel   Direction  Handshake                   Payload
// req       in         req_valid / req_ready       axpl_pkg::req_t (write or evaluate)
// rsp       out        rsp_valid / rsp_ready       axpl_pkg::rsp_t (one per evaluate)
// apb       in/out     psel penable pwrite pready  points_axis0..3 at 0x0, 0x4, 0x8, 0xC
//
// A write transaction is done by the back end in its idle state.
// An evaluate transaction clamps below, clamps above (n breakpoints in use) or
// interpolates on segment j; an interpolated result goes through the multiply and
// the 33-step restoring divider.
// Reset clears the queue, the sequencer and the result valid; the point counts reset to 2.
// A two-entry command queue lets req keep flowing while the back end works or rsp stalls.
module axis_piecewise_linear_unmap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [axpl_pkg::PADDR_W-1:0]  paddr,
	input  logic [axpl_pkg::PDATA_W-1:0]  pwdata,
	output logic [axpl_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  axpl_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output axpl_pkg::rsp_t                rsp
);
	import axpl_pkg::*;

	// Point-count registers, one per axis
	logic [NUM_CFG-1:0][CNT_W-1:0] pts_q;
	logic [$clog2(NUM_CFG)-1:0]    reg_sel;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	assign reg_sel = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = PDATA_W'(pts_q[reg_sel]);

	// Write at the access phase; keep only the count bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				pts_q[i] <= CNT_W'(2);
			end
		end else if (psel && penable && pwrite) begin
			pts_q[reg_sel] <= pwdata[CNT_W-1:0];
		end
	end

	// Front: accept, clamp the point count, drop transactions with no effect, queue
	axpl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.points    (pts_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// Back: breakpoint table, segment search, multiply, divide, result register
	axpl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

@@ sv/axpl_front.sv @@
module axpl_front (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              req_valid,
	output logic                                              req_ready,
	input  axpl_pkg::req_t                                    req,
	input  logic [axpl_pkg::NUM_CFG-1:0][axpl_pkg::CNT_W-1:0] points,
	output logic                                              cmd_valid,
	input  logic                                              cmd_pop,
	output axpl_pkg::cmd_t                                    cmd
);
	import axpl_pkg::*;

	cmd_t              q_q [QDEPTH];
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic [CNT_W-1:0] cnt_cfg;
	logic [CNT_W:0]   n_use;
	logic             keep;
	logic             push;
	cmd_t             cmd_new;

	// Classify: clamp the point count, drop items that address nothing
	always_comb begin
		cnt_cfg = points[req.axis_index];
		if (cnt_cfg == '0) begin
			n_use = (CNT_W+1)'(1);
		end else if ({1'b0, cnt_cfg} > (CNT_W+1)'(MAX_POINTS)) begin
			n_use = (CNT_W+1)'(MAX_POINTS);
		end else begin
			n_use = {1'b0, cnt_cfg};
		end
		keep = (int'(req.axis_index) < NUM_AXES) &&
			((req.op == OP_EVAL) || (int'(req.point_index) < MAX_POINTS));
		cmd_new.kind       = (req.op == OP_EVAL) ? CMD_EVAL : CMD_WRITE;
		cmd_new.axis       = req.axis_index;
		cmd_new.point      = PT_W'(req.point_index);
		cmd_new.last       = PT_W'(n_use - 1'b1);
		cmd_new.blend      = req.blend_coord;
		cmd_new.design_val = req.design_coord;
		cmd_new.query      = req.query_coord;
	end

	assign req_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign push      = req_valid && req_ready && keep;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cmd_new;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= QDEPTH)
		else $error("command queue count beyond depth");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("command queue lost a push");

endmodule

@@ sv/axpl_back.sv @@
module axpl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  axpl_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output axpl_pkg::rsp_t rsp
);
	import axpl_pkg::*;

	bk_state_t state_q, state_d;

	mem_word_t mem [DEPTH];
	mem_word_t rd_q;
	mem_word_t prev_q;

	logic [AXIS_W-1:0]      axis_q;
	logic [BL_W-1:0]        query_q;
	logic [PT_W-1:0]        last_q;
	logic [PT_W-1:0]        j_q;
	logic signed [DS_W-1:0] lo_q;
	logic                   neg_q;
	logic [MAG_W-1:0]       mag_q;
	logic [BL_W-1:0]        off_q;
	logic [BL_W-1:0]        den_q;
	logic [REM_W-1:0]       rem_q;
	logic [MAG_W-1:0]       quo_q;
	logic [DIVC_W-1:0]      divc_q;
	logic signed [DS_W-1:0] res_design_q;
	region_t                res_region_q;
	logic [SEG_W-1:0]       res_seg_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                    mem_we;
	logic                    load_out;
	logic                    hit;
	logic [PT_W-1:0]         rd_pt;
	logic [AXIS_W-1:0]       rd_axis;
	logic [ADDR_W-1:0]       rd_addr;
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]        mag;
	logic [PROD_W-1:0]       num;
	logic [REM_W:0]          trial;
	logic                    ge;
	logic [MAG_W:0]          sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		mem_we   = 1'b0;
		load_out = 1'b0;
		rd_pt    = '0;
		hit      = (query_q <= rd_q.blend);
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.kind == CMD_WRITE) begin
						mem_we = 1'b1;
					end else begin
						state_d = BK_FIRST;
					end
				end
			end
			BK_FIRST: begin
				rd_pt = PT_W'(1);
				if (hit || last_q == '0) begin
					state_d = BK_OUT;
				end else begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				rd_pt = j_q + 1'b1;
				if (hit) begin
					state_d = BK_MUL;
				end else if (j_q == last_q) begin
					state_d = BK_OUT;
				end
			end
			BK_MUL: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (divc_q == DIVC_W'(DIV_STEPS - 1)) begin
					state_d = BK_FIX;
				end
			end
			BK_FIX: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_axis = (state_q == BK_IDLE) ? cmd.axis : axis_q;
		rd_addr = mem_addr(rd_axis, rd_pt);
		diff    = MAG_W'(rd_q.design_val) - MAG_W'(prev_q.design_val);
		mag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
		num     = PROD_W'(off_q) * PROD_W'(mag_q) + PROD_W'(den_q >> 1);
		trial   = {rem_q, quo_q[MAG_W-1]};
		ge      = (trial >= {1'b0, den_q});
		sum     = neg_q ? ((MAG_W+1)'(lo_q) - (MAG_W+1)'(quo_q))
			: ((MAG_W+1)'(lo_q) + (MAG_W+1)'(quo_q));
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr(cmd.axis, cmd.point)] <= '{blend: cmd.blend,
				design_val: cmd.design_val};
		end
		rd_q <= mem[rd_addr];
		case (state_q)
			BK_IDLE: begin
				axis_q  <= cmd.axis;
				query_q <= cmd.query;
				last_q  <= cmd.last;
				j_q     <= PT_W'(1);
			end
			BK_FIRST: begin
				prev_q       <= rd_q;
				res_design_q <= rd_q.design_val;
				res_seg_q    <= '0;
				res_region_q <= hit ? REGION_BELOW : REGION_ABOVE;
			end
			BK_SCAN: begin
				prev_q    <= rd_q;
				j_q       <= j_q + 1'b1;
				res_seg_q <= SEG_W'(j_q);
				if (hit) begin
					lo_q         <= prev_q.design_val;
					neg_q        <= diff[MAG_W-1];
					mag_q        <= mag;
					off_q        <= query_q - prev_q.blend;
					den_q        <= rd_q.blend - prev_q.blend;
					res_region_q <= REGION_INTERP;
				end else begin
					res_design_q <= rd_q.design_val;
					res_region_q <= REGION_ABOVE;
				end
			end
			BK_MUL: begin
				rem_q  <= num[PROD_W-1:MAG_W];
				quo_q  <= num[MAG_W-1:0];
				divc_q <= '0;
			end
			BK_DIV: begin
				rem_q  <= ge ? REM_W'(trial - {1'b0, den_q}) : trial[REM_W-1:0];
				quo_q  <= {quo_q[MAG_W-2:0], ge};
				divc_q <= divc_q + 1'b1;
			end
			BK_FIX: begin
				res_design_q <= sum[DS_W-1:0];
			end
			default: begin
			end
		endcase
		if (load_out) begin
			rsp_q.mapped_design <= res_design_q;
			rsp_q.region        <= res_region_q;
			rsp_q.segment       <= res_seg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_mul_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_MUL) |-> ((den_q != '0) && (off_q <= den_q)))
		else $error("segment offset outside segment");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_OUT && rsp_valid_q && !rsp_ready) |=> (state_q == BK_OUT))
		else $error("result register overwritten while stalled");

endmodule

@@ tb/sv/axis_piecewise_linear_unmap_tb.sv @@
// Testbench for axis_piecewise_linear_unmap.
//
// Breakpoint writes and evaluate requests go in through the req channel. Each
// evaluate comes back as one mapped design value on the rsp channel. The bench
// keeps its own copy of the four axis tables and the point counts. At every
// accepted req transaction it updates that copy or works out the mapped value
// it expects, and it queues that value. A monitor pops the queue at every
// accepted rsp transaction and compares each field.
//
// The run goes in order:
//   - load every slot of every axis, so that no evaluate reads an empty slot
//   - directed cases: field extremes, clamping on both sides, rounding ties,
//     unsorted breakpoints, point counts of zero, one, eight and beyond eight
//   - a long rsp stall that fills the block and pushes back on req
//   - random phases, each after a full drain and new point counts
// Point counts change only while the block is idle.

module axis_piecewise_linear_unmap_tb;
	import axpl_pkg::*;

	localparam int REG_POINTS_AXIS0 = 0;     // byte address of points_axis0
	localparam int REG_STRIDE       = 4;     // byte spacing of the count registers
	localparam int SETTLE_CYCLES    = 64;    // covers the slowest evaluate
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_PHASES    = 6;
	localparam int RANDOM_ITEMS     = 384;
	localparam int HOLD_CYCLES      = 300;
	localparam int BLEND_ONE        = 65536; // 1.0 in Q1.16

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;

	// Shadow of the block: breakpoint tables and point counts
	logic [BL_W-1:0]        bp_blend  [NUM_AXES][MAX_POINTS];
	logic signed [DS_W-1:0] bp_design [NUM_AXES][MAX_POINTS];
	logic [CNT_W-1:0]       points_cfg[NUM_AXES];

	rsp_t        mapped_q[$];    // mapped results still owed by the block
	int          err_count   = 0;
	int          cycle_count = 0;
	bit          req_idle_on = 1'b1;
	bit          rsp_idle_on = 1'b1;
	int unsigned rsp_hold_len = 0;

	axis_piecewise_linear_unmap uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Guard against a hang: any stuck handshake lands here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// lo + off * (hi - lo) / den, rounded to nearest with ties away from zero.
	// Work on the magnitude of the span so the rounding is symmetric.
	function automatic logic signed [DS_W-1:0] lerp_nearest(
		input logic signed [DS_W-1:0] lo,
		input logic signed [DS_W-1:0] hi,
		input logic [BL_W-1:0]        off,
		input logic [BL_W-1:0]        den);
		longint          span;
		longint          sum;
		longint unsigned mag;
		longint unsigned quo;
		bit              neg;
		span = longint'(hi) - longint'(lo);
		neg  = span < 0;
		mag  = neg ? longint'(-span) : longint'(span);
		quo  = (64'(off) * mag + 64'(den >> 1)) / 64'(den);
		sum  = neg ? longint'(lo) - longint'(quo) : longint'(lo) + longint'(quo);
		return DS_W'(sum);
	endfunction

	// Expected mapped value for one evaluate request.
	function automatic rsp_t map_coord(input req_t item);
		rsp_t            res;
		int unsigned     ax;
		int unsigned     n;
		bit              found;
		logic [BL_W-1:0] lo_bl;
		logic [BL_W-1:0] hi_bl;
		ax = 32'(item.axis_index);
		// A count of zero acts as one; counts past the table size saturate.
		n = 32'(points_cfg[ax]);
		if (n == 0)
			n = 1;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		if (item.query_coord <= bp_blend[ax][0]) begin
			res.mapped_design = bp_design[ax][0];
			res.region        = REGION_BELOW;
			res.segment       = '0;
		end else begin
			res.mapped_design = bp_design[ax][n-1];
			res.region        = REGION_ABOVE;
			res.segment       = SEG_W'(n - 1);
			found = 1'b0;
			// First breakpoint at or above the query wins, sorted or not.
			for (int j = 1; j < n && !found; j++) begin
				if (item.query_coord <= bp_blend[ax][j]) begin
					lo_bl = bp_blend[ax][j-1];
					hi_bl = bp_blend[ax][j];
					res.mapped_design = lerp_nearest(bp_design[ax][j-1], bp_design[ax][j],
						item.query_coord - lo_bl, hi_bl - lo_bl);
					res.region  = REGION_INTERP;
					res.segment = SEG_W'(j);
					found = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// Advance the shadow on an accepted req transaction.
	function automatic void predict_item(input req_t item);
		if (item.op == OP_WRITE) begin
			bp_blend[item.axis_index][item.point_index]  = item.blend_coord;
			bp_design[item.axis_index][item.point_index] = item.design_coord;
		end else begin
			mapped_q.push_back(map_coord(item));
		end
	endfunction

	// Offer one req transaction after a random gap and hold it until taken.
	// Valid is only lowered when a gap follows, so it never toggles within a step.
	task automatic send_item(input req_t item);
		int unsigned gap;
		gap = req_idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predict_item(item);
	endtask

	task automatic put_point(input int ax, input int slot, input int unsigned blend,
		input logic [DS_W-1:0] design_val);
		req_t item;
		item.op           = OP_WRITE;
		item.axis_index   = AXIS_W'(ax);
		item.point_index  = SLOT_W'(slot);
		item.blend_coord  = BL_W'(blend);
		item.design_coord = design_val;
		item.query_coord  = BL_W'($urandom_range(0, BLEND_ONE));
		send_item(item);
	endtask

	task automatic eval_point(input int ax, input int unsigned query);
		req_t item;
		item.op           = OP_EVAL;
		item.axis_index   = AXIS_W'(ax);
		item.point_index  = SLOT_W'($urandom_range(0, MAX_POINTS - 1));
		item.blend_coord  = BL_W'($urandom_range(0, BLEND_ONE));
		item.design_coord = $urandom();
		item.query_coord  = BL_W'(query);
		send_item(item);
	endtask

	// Drop valid, wait until every mapped result is back, then let the back end
	// finish any trailing breakpoint write before the caller touches registers.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (mapped_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one point count over APB, then read it back in the next access.
	task automatic set_point_count(input int ax, input logic [CNT_W-1:0] cnt);
		logic [PADDR_W-1:0] addr;
		addr = PADDR_W'(REG_POINTS_AXIS0 + REG_STRIDE * ax);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= PDATA_W'(cnt);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		points_cfg[ax] = cnt;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== PDATA_W'(cnt)) begin
			$error("prdata: expected %0d, got %0d", cnt, prdata);
			err_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DS_W-1:0] pick_design();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return DS_W'(int'($urandom_range(0, 200)) - 100);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0:       return CNT_W'(0);
			1:       return CNT_W'(1);
			2:       return CNT_W'(MAX_POINTS);
			3:       return {CNT_W{1'b1}};
			default: return CNT_W'($urandom_range(2, MAX_POINTS + 2));
		endcase
	endfunction

	// Half the breakpoints are well-ordered (slot-wise rising) so queries land inside
	// real segments; the rest are end or free coordinates that scramble the order.
	function automatic req_t random_item();
		req_t        item;
		int unsigned ax;
		int unsigned q;
		ax = $urandom_range(0, NUM_AXES - 1);
		item.op           = ($urandom_range(0, 9) < 6) ? OP_EVAL : OP_WRITE;
		item.axis_index   = AXIS_W'(ax);
		item.point_index  = SLOT_W'($urandom_range(0, MAX_POINTS - 1));
		item.design_coord = pick_design();
		case ($urandom_range(0, 7))
			0:       item.blend_coord = '0;
			1:       item.blend_coord = BL_W'(BLEND_ONE);
			2, 3:    item.blend_coord = BL_W'($urandom_range(0, BLEND_ONE));
			default: item.blend_coord = BL_W'(item.point_index * 8192 + $urandom_range(0, 8191));
		endcase
		case ($urandom_range(0, 7))
			0:       q = 0;
			1:       q = BLEND_ONE;
			2:       q = 32'(bp_blend[ax][$urandom_range(0, MAX_POINTS - 1)]);
			3: begin
				q = 32'(bp_blend[ax][$urandom_range(0, MAX_POINTS - 1)]);
				q = (q < BLEND_ONE) ? q + 1 : q;
			end
			4: begin
				q = 32'(bp_blend[ax][$urandom_range(0, MAX_POINTS - 1)]);
				q = (q > 0) ? q - 1 : q;
			end
			default: q = $urandom_range(0, BLEND_ONE);
		endcase
		item.query_coord = BL_W'(q);
		return item;
	endfunction

	// Fill every slot so that later evaluates never read an unwritten entry.
	task automatic test_load_tables();
		for (int ax = 0; ax < NUM_AXES; ax++)
			for (int s = 0; s < MAX_POINTS; s++)
				put_point(ax, s, s * 8192 + $urandom_range(0, 8191), $urandom());
	endtask

	// Full-scale coordinates and design values, clamp below and above.
	task automatic test_extremes();
		put_point(0, 0, 0, 32'h8000_0000);
		put_point(0, 1, BLEND_ONE, 32'h7FFF_FFFF);
		eval_point(0, 0);
		eval_point(0, BLEND_ONE);
		eval_point(0, BLEND_ONE / 2);
		eval_point(0, 1);
		put_point(1, 0, 100, 5000);
		put_point(1, 1, 200, -5000);
		eval_point(1, 300);
		eval_point(1, 150);
		eval_point(1, 100);
	endtask

	// Exact halves must round away from zero on both signs.
	task automatic test_round_ties();
		put_point(2, 0, 10, 0);
		put_point(2, 1, 12, 1);
		eval_point(2, 11);
		put_point(2, 1, 12, -1);
		eval_point(2, 11);
		put_point(2, 1, 12, 3);
		eval_point(2, 11);
	endtask

	// Breakpoints out of order: the search stops at the first one at or above.
	task automatic test_unsorted();
		put_point(3, 0, 500, 1000);
		put_point(3, 1, 100, 2000);
		eval_point(3, 600);
		eval_point(3, 300);
	endtask

	// Counts of zero, one, eight and fifteen, one per axis.
	task automatic test_point_counts();
		drain_results();
		set_point_count(0, CNT_W'(0));
		set_point_count(1, CNT_W'(1));
		set_point_count(2, CNT_W'(MAX_POINTS));
		set_point_count(3, {CNT_W{1'b1}});
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			eval_point(ax, BLEND_ONE);
			eval_point(ax, $urandom_range(1, BLEND_ONE - 1));
		end
	endtask

	// Hold rsp off for a long stretch while req keeps coming back to back,
	// so the command queue fills and req_ready drops.
	task automatic test_backpressure();
		drain_results();
		req_idle_on  = 1'b0;
		rsp_hold_len = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			eval_point($urandom_range(0, NUM_AXES - 1), $urandom_range(0, BLEND_ONE));
		drain_results();
		req_idle_on = 1'b1;
	endtask

	// Each phase starts from an idle block: the sender pauses until every
	// mapped result is back, then the counts change.
	task automatic test_random_phase(input int phase, input int n_items);
		int unsigned mode;
		drain_results();
		for (int ax = 0; ax < NUM_AXES; ax++)
			set_point_count(ax, pick_count());
		mode = (phase == 0) ? 0 : $urandom_range(0, 3);
		req_idle_on = mode[0];
		rsp_idle_on = mode[1];
		for (int i = 0; i < n_items; i++)
			send_item(random_item());
	endtask

	// Receiver: random stall before each transaction, or the long hold on request.
	initial begin : rsp_sink
		int unsigned stall;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rsp_idle_on ? $urandom_range(0, 15) : 0;
			if (rsp_hold_len != 0) begin
				stall = rsp_hold_len;
				rsp_hold_len = 0;
			end
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// Compare every accepted rsp transaction against the oldest expectation.
	always @(posedge clk) begin : check_mapped
		rsp_t want;
		if (arst_n === 1'b1 && rsp_valid && rsp_ready) begin
			if (mapped_q.size() == 0) begin
				$error("unexpected result: mapped_design %0d region %0d segment %0d",
					rsp.mapped_design, rsp.region, rsp.segment);
				err_count++;
			end else begin
				want = mapped_q.pop_front();
				if (rsp.mapped_design !== want.mapped_design) begin
					$error("mapped_design: expected %0d, got %0d",
						want.mapped_design, rsp.mapped_design);
					err_count++;
				end
				if (rsp.region !== want.region) begin
					$error("region: expected %0d, got %0d", want.region, rsp.region);
					err_count++;
				end
				if (rsp.segment !== want.segment) begin
					$error("segment: expected %0d, got %0d", want.segment, rsp.segment);
					err_count++;
				end
			end
		end
	end

	initial begin
		for (int ax = 0; ax < NUM_AXES; ax++)
			points_cfg[ax] = CNT_W'(2);
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_tables();
		test_extremes();
		test_round_ties();
		test_unsorted();
		test_point_counts();
		test_backpressure();
		for (int p = 0; p < RANDOM_PHASES; p++)
			test_random_phase(p, RANDOM_ITEMS / RANDOM_PHASES);
		drain_results();

		if (mapped_q.size() != 0) begin
			$error("%0d mapped results never arrived", mapped_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
